// File: src/nndc_pkg.sv
// Shared constants, codes and controller/datapath link types for the
// nearest-neighbour distance clamp. No dependencies.
package nndc_pkg;

   localparam int MAX_REF_POINTS = 1024;
   localparam int COORD_BITS     = 24;
   localparam int ADDR_BITS      = $clog2(MAX_REF_POINTS);
   localparam int CNT_BITS       = $clog2(MAX_REF_POINTS + 1);
   localparam int POINT_BITS     = 3 * COORD_BITS;
   localparam int SQ_BITS        = 2 * COORD_BITS + 2;
   localparam int ROOT_BITS      = SQ_BITS / 2;
   localparam int DIST_BITS      = 25;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 25;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_BOX_MIN_X    = 3'd0,
      REG_BOX_MIN_Y    = 3'd1,
      REG_BOX_MIN_Z    = 3'd2,
      REG_BOX_MAX_X    = 3'd3,
      REG_BOX_MAX_Y    = 3'd4,
      REG_BOX_MAX_Z    = 3'd5,
      REG_MAX_DISTANCE = 3'd6
   } csr_reg_type;

   localparam logic signed [COORD_BITS-1:0] BOX_MIN_RESET = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] BOX_MAX_RESET = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [DIST_BITS-1:0]         MAX_DIST_RESET = {DIST_BITS{1'b1}};

   typedef struct packed {
      logic accept;
      logic query_start;
      logic scan_issue;
      logic sqrt_start;
      logic out_load;
   } nndc_cmd_type;

   typedef struct packed {
      logic skip;
      logic scan_last;
      logic pipe_busy;
      logic sqrt_done;
      logic out_busy;
   } nndc_status_type;

endpackage

// File: src/nndc_if.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on nndc_pkg.
interface nndc_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              mode;
   logic signed [nndc_pkg::COORD_BITS-1:0]  coord_x;
   logic signed [nndc_pkg::COORD_BITS-1:0]  coord_y;
   logic signed [nndc_pkg::COORD_BITS-1:0]  coord_z;
   modport source (output valid, mode, coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, mode, coord_x, coord_y, coord_z, output ready);
endinterface

interface nndc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [nndc_pkg::DIST_BITS-1:0]   distance;
   logic                             outside_box;
   modport source (output valid, distance, outside_box, input ready);
   modport sink   (input valid, distance, outside_box, output ready);
endinterface

interface nndc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [nndc_pkg::CSR_IDX_BITS-1:0]   index;
   logic [nndc_pkg::CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/nndc_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on nndc_pkg.
module nndc_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [nndc_pkg::SQ_BITS-1:0]      radicand,
   output logic                              done,
   output logic [nndc_pkg::ROOT_BITS-1:0]    root
);
   localparam int REM_BITS  = nndc_pkg::ROOT_BITS + 3;
   localparam int ITER_BITS = $clog2(nndc_pkg::ROOT_BITS + 1);

   logic [nndc_pkg::SQ_BITS-1:0]   rad_ff, rad_in;
   logic [REM_BITS-1:0]            rem_ff, rem_in;
   logic [nndc_pkg::ROOT_BITS-1:0] root_ff, root_in;
   logic [ITER_BITS-1:0]           iter_ff, iter_in;
   logic                           done_ff, done_in;
   logic [REM_BITS-1:0]            rem_shift;
   logic [REM_BITS-1:0]            trial;

   always_comb begin
      rem_shift = {rem_ff[REM_BITS-3:0], rad_ff[nndc_pkg::SQ_BITS-1 -: 2]};
      trial     = REM_BITS'({root_ff, 2'b01});
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      iter_in   = iter_ff;
      done_in   = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         iter_in = ITER_BITS'(nndc_pkg::ROOT_BITS);
      end else if (iter_ff != '0) begin
         rad_in  = {rad_ff[nndc_pkg::SQ_BITS-3:0], 2'b00};
         iter_in = iter_ff - 1'b1;
         done_in = (iter_ff == ITER_BITS'(1));
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[nndc_pkg::ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[nndc_pkg::ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         iter_ff <= iter_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: src/nndc_datapath.sv
// Datapath: configuration registers, reference point memory, distance
// pipeline, running minimum, square root and response register.
// Depends on nndc_pkg and nndc_isqrt.
module nndc_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  nndc_pkg::nndc_cmd_type                  cmd,
   output nndc_pkg::nndc_status_type               status,
   input  logic [1:0]                              in_mode,
   input  logic signed [nndc_pkg::COORD_BITS-1:0]  in_x,
   input  logic signed [nndc_pkg::COORD_BITS-1:0]  in_y,
   input  logic signed [nndc_pkg::COORD_BITS-1:0]  in_z,
   input  logic                                    csr_write,
   input  logic [nndc_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [nndc_pkg::CSR_DATA_BITS-1:0]      csr_data,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [nndc_pkg::DIST_BITS-1:0]          out_distance,
   output logic                                    out_outside
);
   localparam int CB = nndc_pkg::COORD_BITS;
   localparam int AB = nndc_pkg::ADDR_BITS;
   localparam int NB = nndc_pkg::CNT_BITS;
   localparam int SB = nndc_pkg::SQ_BITS;
   localparam int DB = nndc_pkg::DIST_BITS;

   // configuration
   logic signed [CB-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic signed [CB-1:0] max_x_ff, max_y_ff, max_z_ff;
   logic [DB-1:0]        max_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff    <= nndc_pkg::BOX_MIN_RESET;
         min_y_ff    <= nndc_pkg::BOX_MIN_RESET;
         min_z_ff    <= nndc_pkg::BOX_MIN_RESET;
         max_x_ff    <= nndc_pkg::BOX_MAX_RESET;
         max_y_ff    <= nndc_pkg::BOX_MAX_RESET;
         max_z_ff    <= nndc_pkg::BOX_MAX_RESET;
         max_dist_ff <= nndc_pkg::MAX_DIST_RESET;
      end else if (csr_write) begin
         case (csr_index)
            nndc_pkg::REG_BOX_MIN_X:    min_x_ff    <= csr_data[CB-1:0];
            nndc_pkg::REG_BOX_MIN_Y:    min_y_ff    <= csr_data[CB-1:0];
            nndc_pkg::REG_BOX_MIN_Z:    min_z_ff    <= csr_data[CB-1:0];
            nndc_pkg::REG_BOX_MAX_X:    max_x_ff    <= csr_data[CB-1:0];
            nndc_pkg::REG_BOX_MAX_Y:    max_y_ff    <= csr_data[CB-1:0];
            nndc_pkg::REG_BOX_MAX_Z:    max_z_ff    <= csr_data[CB-1:0];
            nndc_pkg::REG_MAX_DISTANCE: max_dist_ff <= csr_data[DB-1:0];
            default: ;
         endcase
      end
   end

   // point store and fill count
   logic [nndc_pkg::POINT_BITS-1:0] store_mem [nndc_pkg::MAX_REF_POINTS];
   logic [NB-1:0]                   count_ff, count_in;
   logic                            store_we;

   always_comb begin
      count_in = count_ff;
      store_we = 1'b0;
      if (cmd.accept) begin
         case (in_mode)
            nndc_pkg::MODE_CLEAR: count_in = '0;
            nndc_pkg::MODE_LOAD: begin
               if (count_ff < NB'(nndc_pkg::MAX_REF_POINTS)) begin
                  store_we = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // query capture and box gate
   logic signed [CB-1:0] q_x_ff, q_y_ff, q_z_ff;
   logic                 outside_ff, skip_ff;
   logic                 outside_now;

   assign outside_now = (in_x < min_x_ff) || (in_x >= max_x_ff) ||
                        (in_y < min_y_ff) || (in_y >= max_y_ff) ||
                        (in_z < min_z_ff) || (in_z >= max_z_ff);

   // scan pipeline: read, abs difference, square, sum and minimum
   logic [AB-1:0]                   addr_ff, addr_in;
   logic [nndc_pkg::POINT_BITS-1:0] rd_data_ff;
   logic                            v1_ff, v2_ff, v3_ff;
   logic [CB-1:0]                   ad_x_ff, ad_y_ff, ad_z_ff;
   logic [2*CB-1:0]                 sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SB-1:0]                   best_ff, best_in;
   logic [SB-1:0]                   sum;

   function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] a,
                                              input logic signed [CB-1:0] b);
      logic signed [CB:0] d;
      d = {a[CB-1], a} - {b[CB-1], b};
      abs_diff = d[CB] ? CB'(-d) : d[CB-1:0];
   endfunction

   assign sum = SB'(sq_x_ff) + SB'(sq_y_ff) + SB'(sq_z_ff);

   always_comb begin
      addr_in = addr_ff;
      best_in = best_ff;
      if (cmd.query_start) begin
         addr_in = '0;
         best_in = '1;
      end else begin
         if (cmd.scan_issue) begin
            addr_in = addr_ff + 1'b1;
         end
         if (v3_ff && (sum < best_ff)) begin
            best_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[count_ff[AB-1:0]] <= {in_x, in_y, in_z};
      end
      rd_data_ff <= store_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         best_ff  <= '1;
      end else begin
         count_ff <= count_in;
         v1_ff    <= cmd.scan_issue;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         best_ff  <= best_in;
      end
      addr_ff <= addr_in;
      if (cmd.query_start) begin
         q_x_ff     <= in_x;
         q_y_ff     <= in_y;
         q_z_ff     <= in_z;
         outside_ff <= outside_now;
         skip_ff    <= outside_now || (count_ff == '0);
      end
      ad_x_ff <= abs_diff(q_x_ff, rd_data_ff[3*CB-1 -: CB]);
      ad_y_ff <= abs_diff(q_y_ff, rd_data_ff[2*CB-1 -: CB]);
      ad_z_ff <= abs_diff(q_z_ff, rd_data_ff[CB-1 -: CB]);
      sq_x_ff <= ad_x_ff * ad_x_ff;
      sq_y_ff <= ad_y_ff * ad_y_ff;
      sq_z_ff <= ad_z_ff * ad_z_ff;
   end

   // square root of the minimum
   logic                          sqrt_done;
   logic [nndc_pkg::ROOT_BITS-1:0] root;

   nndc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (best_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   // response register
   logic          out_valid_ff;
   logic [DB-1:0] out_dist_ff, dist_sel;
   logic          out_outside_ff;

   always_comb begin
      if (skip_ff) begin
         dist_sel = max_dist_ff;
      end else if (DB'(root) < max_dist_ff) begin
         dist_sel = DB'(root);
      end else begin
         dist_sel = max_dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_dist_ff    <= dist_sel;
         out_outside_ff <= outside_ff;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_distance = out_dist_ff;
   assign out_outside  = out_outside_ff;

   assign status.skip      = skip_ff;
   assign status.scan_last = ({1'b0, addr_ff} + NB'(1)) == count_ff;
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;
   assign status.sqrt_done = sqrt_done;
   assign status.out_busy  = out_valid_ff && !out_ready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NB'(nndc_pkg::MAX_REF_POINTS))
      else $error("reference count beyond capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !status.out_busy)
      else $error("response overwritten before it was taken");

   a_sqrt_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_start |-> !status.pipe_busy)
      else $error("square root started with scan still in flight");

   a_best_monotone: assert property (@(posedge clock) disable iff (reset)
      !cmd.query_start |=> best_ff <= $past(best_ff))
      else $error("running minimum grew during a scan");

endmodule

// File: src/nndc_ctrl.sv
// Controller state machine: takes requests, sequences the scan, the square
// root and the response load. Depends on nndc_pkg.
module nndc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [1:0]                  req_mode,
   output logic                        req_ready,
   input  nndc_pkg::nndc_status_type   status,
   output nndc_pkg::nndc_cmd_type      cmd
);
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_SQRT   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && (req_mode == nndc_pkg::MODE_QUERY)) begin
               cmd.query_start = 1'b1;
               state_in        = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.skip ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last point to reach the minimum
            if (!status.pipe_busy) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/nearest_neighbor_distance_clamp.sv
// Top level of the nearest-neighbour distance clamp.
// Depends on nndc_pkg, nndc_if, nndc_ctrl and nndc_datapath.
//
//   Port     Dir   Payload                                  Use
//   req_ch   in    mode, coord_x, coord_y, coord_z          clear, load, query
//   rsp_ch   out   distance, outside_box                    one per query
//   csr_ch   in    index, data                              register writes
//
// Clear, load and mode 3 are taken in the idle state. A query outside the box
// or on an empty store skips the scan and the square root; otherwise its time is
// set by the one-point-per-cycle scan of the N stored points through the single
// memory read port and by the bit-serial square root. Reset is synchronous and
// empties the store; register writes are taken every cycle. A stalled
// response holds in its register while loads and clears are still taken.
module nearest_neighbor_distance_clamp (
   input  logic       clock,
   input  logic       reset,
   nndc_req_if.sink   req_ch,
   nndc_rsp_if.source rsp_ch,
   nndc_csr_if.sink   csr_ch
);
   nndc_pkg::nndc_cmd_type    cmd;
   nndc_pkg::nndc_status_type status;

   assign csr_ch.ready = 1'b1;

   nndc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nndc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_mode      (req_ch.mode),
      .in_x         (req_ch.coord_x),
      .in_y         (req_ch.coord_y),
      .in_z         (req_ch.coord_z),
      .csr_write    (csr_ch.valid),
      .csr_index    (csr_ch.index),
      .csr_data     (csr_ch.data),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .out_distance (rsp_ch.distance),
      .out_outside  (rsp_ch.outside_box)
   );

endmodule

// File: dv/tb_nearest_neighbor_distance_clamp.sv
`timescale 1ns / 1ps
// Self-checking bench for nearest_neighbor_distance_clamp: a scoreboard class keeps its own
// point store and box settings and predicts each query's clamped nearest distance.
// Depends on nndc_pkg, the nndc_if interfaces and the block's sources.
module tb_nearest_neighbor_distance_clamp;

   localparam logic [1:0]                        MODE_UNUSED   = 2'd3;
   localparam logic [nndc_pkg::CSR_IDX_BITS-1:0] REG_UNUSED    = 3'd7;
   localparam int                                IDLE_PCT      = 38;
   localparam int                                SETTLE_CYCLES = 40;

   typedef logic signed [nndc_pkg::COORD_BITS-1:0] coord_type;
   typedef logic [nndc_pkg::DIST_BITS-1:0]         dist_type;
   typedef logic [nndc_pkg::CSR_IDX_BITS-1:0]      csr_index_type;
   typedef logic [nndc_pkg::CSR_DATA_BITS-1:0]     csr_data_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      dist_type distance;
      logic     outside_box;
   } distance_result_type;

   class nn_distance_scoreboard;
      coord_type            box_lo[3];
      coord_type            box_hi[3];
      dist_type             clamp_value;
      point_type            points[nndc_pkg::MAX_REF_POINTS];
      int unsigned          point_count;
      distance_result_type  expected_distances[$];
      int unsigned          failures;

      function new();
         for (int a = 0; a < 3; a++) begin
            box_lo[a] = nndc_pkg::BOX_MIN_RESET;
            box_hi[a] = nndc_pkg::BOX_MAX_RESET;
         end
         clamp_value = nndc_pkg::MAX_DIST_RESET;
         point_count = 0;
         failures    = 0;
      endfunction

      function void write_reg(csr_index_type index, csr_data_type data);
         case (index)
            nndc_pkg::REG_BOX_MIN_X:    box_lo[0] = data[nndc_pkg::COORD_BITS-1:0];
            nndc_pkg::REG_BOX_MIN_Y:    box_lo[1] = data[nndc_pkg::COORD_BITS-1:0];
            nndc_pkg::REG_BOX_MIN_Z:    box_lo[2] = data[nndc_pkg::COORD_BITS-1:0];
            nndc_pkg::REG_BOX_MAX_X:    box_hi[0] = data[nndc_pkg::COORD_BITS-1:0];
            nndc_pkg::REG_BOX_MAX_Y:    box_hi[1] = data[nndc_pkg::COORD_BITS-1:0];
            nndc_pkg::REG_BOX_MAX_Z:    box_hi[2] = data[nndc_pkg::COORD_BITS-1:0];
            nndc_pkg::REG_MAX_DISTANCE: clamp_value = data[nndc_pkg::DIST_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Build the root one bit at a time, keeping each bit whose square still fits.
      function longint unsigned floor_root(longint unsigned n);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 26; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) root = trial;
         end
         return root;
      endfunction

      function void note_request(logic [1:0] mode, point_type p);
         distance_result_type res;
         longint unsigned     best;
         longint unsigned     dist_sq;
         longint unsigned     root;
         longint              dx;
         longint              dy;
         longint              dz;
         logic                outside;
         case (mode)
            nndc_pkg::MODE_CLEAR: point_count = 0;
            nndc_pkg::MODE_LOAD: begin
               // drop the point once the store is full
               if (point_count < nndc_pkg::MAX_REF_POINTS) begin
                  points[point_count] = p;
                  point_count++;
               end
            end
            nndc_pkg::MODE_QUERY: begin
               outside = (p.x < box_lo[0]) || (p.x >= box_hi[0]) ||
                         (p.y < box_lo[1]) || (p.y >= box_hi[1]) ||
                         (p.z < box_lo[2]) || (p.z >= box_hi[2]);
               res.outside_box = outside;
               res.distance    = clamp_value;
               if (!outside && point_count != 0) begin
                  best = '1;
                  for (int i = 0; i < point_count; i++) begin
                     dx = longint'(p.x) - longint'(points[i].x);
                     dy = longint'(p.y) - longint'(points[i].y);
                     dz = longint'(p.z) - longint'(points[i].z);
                     dist_sq = longint'(dx * dx + dy * dy + dz * dz);
                     if (dist_sq < best) best = dist_sq;
                  end
                  root = floor_root(best);
                  res.distance = (root < clamp_value) ? root[nndc_pkg::DIST_BITS-1:0]
                                                      : clamp_value;
               end
               expected_distances.push_back(res);
            end
            default: ;
         endcase
      endfunction

      function void check_response(dist_type distance, logic outside_box);
         distance_result_type want;
         if (expected_distances.size() == 0) begin
            $error("distance: expected no response, actual %0d (outside_box %0b)",
                   distance, outside_box);
            failures++;
         end else begin
            want = expected_distances.pop_front();
            if (distance !== want.distance) begin
               $error("distance: expected %0d, actual %0d", want.distance, distance);
               failures++;
            end
            if (outside_box !== want.outside_box) begin
               $error("outside_box: expected %0b, actual %0b", want.outside_box, outside_box);
               failures++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic steady_flow;

   nndc_req_if req_ch();
   nndc_rsp_if rsp_ch();
   nndc_csr_if csr_ch();

   nn_distance_scoreboard distance_board = new();

   nearest_neighbor_distance_clamp i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready = steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready)
         distance_board.check_response(rsp_ch.distance, rsp_ch.outside_box);
   end

   function automatic bit take_gap();
      return !steady_flow && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function automatic point_type make_point(int x, int y, int z);
      point_type p;
      p.x = coord_type'(x);
      p.y = coord_type'(y);
      p.z = coord_type'(z);
      return p;
   endfunction

   function automatic coord_type shift_coord(coord_type base, int delta);
      longint v;
      v = longint'(base) + delta;
      if (v > longint'(nndc_pkg::BOX_MAX_RESET)) v = longint'(nndc_pkg::BOX_MAX_RESET);
      if (v < longint'(nndc_pkg::BOX_MIN_RESET)) v = longint'(nndc_pkg::BOX_MIN_RESET);
      return coord_type'(v);
   endfunction

   function automatic coord_type rand_coord(int axis);
      coord_type c;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         c = coord_type'($urandom);
      end else if (pick < 70) begin
         c = shift_coord(0, int'($urandom_range(600)) - 300);
      end else if (pick < 85) begin
         case ($urandom_range(5))
            0:       c = nndc_pkg::BOX_MIN_RESET;
            1:       c = shift_coord(nndc_pkg::BOX_MIN_RESET, 1);
            2:       c = coord_type'(-1);
            3:       c = '0;
            4:       c = shift_coord(nndc_pkg::BOX_MAX_RESET, -1);
            default: c = nndc_pkg::BOX_MAX_RESET;
         endcase
      end else begin
         // land on or next to a box face
         c = shift_coord($urandom_range(1) ? distance_board.box_lo[axis]
                                           : distance_board.box_hi[axis],
                         int'($urandom_range(2)) - 1);
      end
      return c;
   endfunction

   function automatic point_type random_point();
      point_type p;
      p.x = rand_coord(0);
      p.y = rand_coord(1);
      p.z = rand_coord(2);
      return p;
   endfunction

   function automatic point_type query_point();
      point_type p;
      point_type base;
      int        spread;
      if (distance_board.point_count != 0 && $urandom_range(99) < 50) begin
         base   = distance_board.points[$urandom_range(distance_board.point_count - 1)];
         spread = (1 << $urandom_range(15)) >> 1;
         p.x = shift_coord(base.x, int'($urandom_range(2 * spread)) - spread);
         p.y = shift_coord(base.y, int'($urandom_range(2 * spread)) - spread);
         p.z = shift_coord(base.z, int'($urandom_range(2 * spread)) - spread);
      end else begin
         p = random_point();
      end
      return p;
   endfunction

   // Called and returns at a falling edge; valid stays high for a following transaction.
   task automatic send_req(logic [1:0] mode, point_type p);
      while (take_gap()) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.mode    = mode;
      req_ch.coord_x = p.x;
      req_ch.coord_y = p.y;
      req_ch.coord_z = p.z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      distance_board.note_request(mode, p);
      @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type index, csr_data_type data);
      while (take_gap()) begin
         csr_ch.valid = 1'b0;
         @(negedge clock);
      end
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data  = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      distance_board.write_reg(index, data);
      @(negedge clock);
   endtask

   // Hold until every query has answered, then let trailing loads and clears finish.
   task automatic settle();
      req_ch.valid = 1'b0;
      while (distance_board.expected_distances.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_box(point_type lo, point_type hi, dist_type clamp);
      settle();
      csr_write(nndc_pkg::REG_BOX_MIN_X, nndc_pkg::CSR_DATA_BITS'(lo.x));
      csr_write(nndc_pkg::REG_BOX_MIN_Y, nndc_pkg::CSR_DATA_BITS'(lo.y));
      csr_write(nndc_pkg::REG_BOX_MIN_Z, nndc_pkg::CSR_DATA_BITS'(lo.z));
      csr_write(nndc_pkg::REG_BOX_MAX_X, nndc_pkg::CSR_DATA_BITS'(hi.x));
      csr_write(nndc_pkg::REG_BOX_MAX_Y, nndc_pkg::CSR_DATA_BITS'(hi.y));
      csr_write(nndc_pkg::REG_BOX_MAX_Z, nndc_pkg::CSR_DATA_BITS'(hi.z));
      csr_write(nndc_pkg::REG_MAX_DISTANCE, nndc_pkg::CSR_DATA_BITS'(clamp));
      csr_ch.valid = 1'b0;
   endtask

   // Mostly clear/load/query runs on a small store, with some stray and unused transactions.
   task automatic run_random(int budget);
      int done;
      int loads;
      int queries;
      done = 0;
      while (done < budget) begin
         case ($urandom_range(19))
            0: send_req(MODE_UNUSED, random_point());
            1: begin
               send_req(nndc_pkg::MODE_CLEAR, random_point());
               done++;
            end
            default: begin
               if (distance_board.point_count > 48 || $urandom_range(99) < 65) begin
                  send_req(nndc_pkg::MODE_CLEAR, random_point());
                  done++;
               end
               loads   = ($urandom_range(9) == 0) ? 0 : $urandom_range(16, 1);
               queries = $urandom_range(5, 1);
               repeat (loads) send_req(nndc_pkg::MODE_LOAD, random_point());
               repeat (queries) send_req(nndc_pkg::MODE_QUERY, query_point());
               done += loads + queries;
            end
         endcase
      end
   endtask

   initial begin
      reset          = 1'b1;
      steady_flow    = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.mode    = nndc_pkg::MODE_CLEAR;
      req_ch.coord_x = '0;
      req_ch.coord_y = '0;
      req_ch.coord_z = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = nndc_pkg::REG_BOX_MIN_X;
      csr_ch.data    = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // empty store, box faces, coordinate extremes and the unused mode
      send_req(nndc_pkg::MODE_QUERY, make_point(0, 0, 0));
      send_req(nndc_pkg::MODE_QUERY, make_point(-8388608, -8388608, -8388608));
      send_req(nndc_pkg::MODE_QUERY, make_point(8388607, 0, 0));
      send_req(nndc_pkg::MODE_QUERY, make_point(0, 8388607, 0));
      send_req(nndc_pkg::MODE_QUERY, make_point(0, 0, 8388607));
      send_req(MODE_UNUSED, make_point(-1, -1, -1));
      send_req(nndc_pkg::MODE_LOAD, make_point(-8388608, -8388608, -8388608));
      send_req(nndc_pkg::MODE_QUERY, make_point(8388606, 8388606, 8388606));
      send_req(nndc_pkg::MODE_LOAD, make_point(8388607, 8388607, 8388607));
      send_req(nndc_pkg::MODE_QUERY, make_point(8388606, 8388606, 8388606));
      send_req(nndc_pkg::MODE_QUERY, make_point(-8388608, -8388608, -8388608));
      send_req(nndc_pkg::MODE_LOAD, make_point(-1, 0, 1));
      send_req(nndc_pkg::MODE_QUERY, make_point(0, 0, 0));
      send_req(nndc_pkg::MODE_QUERY, make_point(3, 4, 0));
      send_req(MODE_UNUSED, make_point(3, 4, 0));
      send_req(nndc_pkg::MODE_QUERY, make_point(3, 4, 1));
      send_req(nndc_pkg::MODE_CLEAR, make_point(0, 0, 0));
      send_req(nndc_pkg::MODE_QUERY, make_point(5, -5, 5));
      send_req(nndc_pkg::MODE_LOAD, make_point(100, -100, 7));
      send_req(nndc_pkg::MODE_QUERY, make_point(100, -100, 7));
      send_req(nndc_pkg::MODE_QUERY, make_point(-8388608, 8388606, -8388608));
      run_random(75);

      // tight box, small clamp; a write to the unused index must change nothing
      program_box(make_point(-2000, -2000, -2000), make_point(2000, 2000, 2000), 25'd700);
      csr_write(REG_UNUSED, '1);
      csr_ch.valid = 1'b0;
      run_random(75);

      // zero clamp: every inside result collapses to zero
      program_box(make_point(-int'($urandom_range(8388608)), -int'($urandom_range(8388608)),
                             -int'($urandom_range(8388608))),
                  make_point(int'($urandom_range(8388607)), int'($urandom_range(8388607)),
                             int'($urandom_range(8388607))),
                  '0);
      run_random(75);

      // empty box on x, reversed on y and z: every query lands outside
      program_box(make_point(0, 100, 8388607), make_point(0, -100, -8388608), 25'd1);
      run_random(75);

      // widest settings, then overfill the store so the last loads drop
      program_box(make_point(-8388608, -8388608, -8388608),
                  make_point(8388607, 8388607, 8388607), nndc_pkg::MAX_DIST_RESET);
      send_req(nndc_pkg::MODE_CLEAR, random_point());
      repeat (nndc_pkg::MAX_REF_POINTS + 6) send_req(nndc_pkg::MODE_LOAD, random_point());
      repeat (4) send_req(nndc_pkg::MODE_QUERY, query_point());
      send_req(nndc_pkg::MODE_CLEAR, random_point());
      run_random(75);

      // random box around the origin, no idling on any channel
      program_box(make_point(-int'($urandom_range(8388608)), -int'($urandom_range(8388608)),
                             -int'($urandom_range(8388608))),
                  make_point(int'($urandom_range(8388607)), int'($urandom_range(8388607)),
                             int'($urandom_range(8388607))),
                  $urandom_range(1) ? nndc_pkg::DIST_BITS'($urandom_range(4000, 1))
                                    : nndc_pkg::DIST_BITS'($urandom));
      steady_flow = 1'b1;
      run_random(75);
      steady_flow = 1'b0;

      // full box with the smallest non-zero clamp
      program_box(make_point(-8388608, -8388608, -8388608),
                  make_point(8388607, 8388607, 8388607), 25'd1);
      run_random(75);

      settle();
      if (distance_board.failures == 0) begin
         $display("PASS nearest_neighbor_distance_clamp");
      end else begin
         $display("FAIL nearest_neighbor_distance_clamp");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("FAIL nearest_neighbor_distance_clamp");
      $finish;
   end

endmodule
